[design/hebbian_assoc_memory_top_defines.svh]
// Assertion macros for the associative memory block
`ifndef HEBBIAN_ASSOC_MEMORY_TOP_DEFINES_SVH
`define HEBBIAN_ASSOC_MEMORY_TOP_DEFINES_SVH
`ifndef SYNTH
`define HAM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HAM_ASSERT_IMPL(label, ante, cons)
`define HAM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/ham_pkg.sv]
`timescale 1ns / 1ps
package ham_pkg;
    localparam int DIM_DEF         = 4;
    localparam int ELEM_BITS_DEF   = 8;
    localparam int WEIGHT_BITS_DEF = 24;
    localparam int SIM_BITS        = 16;
    localparam int SC_BITS         = 16;   // scaled values: sign + 15 bit magnitude
    localparam int SQ_BITS         = 64;
    localparam logic REQ_TEACH = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_TEACH = 7'b0000010,
        ST_MAC   = 7'b0000100,
        ST_SCALE = 7'b0001000,
        ST_SUMS  = 7'b0010000,
        ST_ROOT  = 7'b0100000,
        ST_DIV   = 7'b1000000
    } ham_state_t;

    typedef struct packed {
        logic teach;
        logic mac;
    } ham_lane_ctl_t;
endpackage

[design/hebbian_assoc_memory_top.sv]
`timescale 1ns / 1ps
// Teach: lanes update one column per cycle; no result.
// Check: recall, max-scan, sum, bit-serial square root (both norms in parallel), multiply
//   and bit-serial divide steps, then the done register; a zero norm goes from the root
//   step straight to done.
// One word in flight; the result register frees the input side once taken.
// Reset (rst_n low, async) clears all weights and control.
module hebbian_assoc_memory_top #(
    parameter int DIM         = ham_pkg::DIM_DEF,
    parameter int ELEM_BITS   = ham_pkg::ELEM_BITS_DEF,
    parameter int WEIGHT_BITS = ham_pkg::WEIGHT_BITS_DEF
)(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic signed [ELEM_BITS-1:0]         elem_0,
    input  logic signed [ELEM_BITS-1:0]         elem_1,
    input  logic signed [ELEM_BITS-1:0]         elem_2,
    input  logic signed [ELEM_BITS-1:0]         elem_3,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ham_pkg::SIM_BITS-1:0] similarity,
    output logic                                zero_norm
);
    import ham_pkg::*;
    `include "hebbian_assoc_memory_top_defines.svh"

    localparam int IDX_BITS = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ACC_BITS = WEIGHT_BITS + ELEM_BITS + 5;

    ham_state_t             st_reg, st_next;
    logic [IDX_BITS-1:0]    col_reg;
    logic signed [ELEM_BITS-1:0] x_reg [DIM];
    logic                   ov_reg;
    logic signed [SIM_BITS-1:0] sim_reg;
    logic                   zn_reg;
    ham_lane_ctl_t          ctl;
    logic [DIM*ACC_BITS-1:0]  rvec;
    logic [DIM*ELEM_BITS-1:0] xvec;
    logic                   m_start, m_done, m_zero;
    logic signed [SIM_BITS-1:0] m_sim;
    logic                   in_acc;

    assign in_stall = (st_reg != ST_IDLE) || ov_reg;
    assign in_acc   = in_valid && !in_stall;
    assign ctl.teach = (st_reg == ST_TEACH);
    assign ctl.mac   = (st_reg == ST_MAC);
    assign m_start   = (st_reg == ST_MAC) && (col_reg == IDX_BITS'(DIM-1));

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
                if (in_acc)
                    st_next = (req_type == REQ_CHECK) ? ST_MAC : ST_TEACH;
            ST_TEACH: if (col_reg == IDX_BITS'(DIM-1)) st_next = ST_IDLE;
            ST_MAC:   if (col_reg == IDX_BITS'(DIM-1)) st_next = ST_DIV;
            ST_DIV:   if (m_done) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            col_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_TEACH || st_reg == ST_MAC)
                col_reg <= (col_reg == IDX_BITS'(DIM-1)) ? '0 : col_reg + IDX_BITS'(1);
            if (m_done)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg[0] <= elem_0;
            x_reg[1] <= elem_1;
            x_reg[2] <= elem_2;
            x_reg[3] <= elem_3;
            for (int k = 4; k < DIM; k++)
                x_reg[k] <= '0;
        end
        if (m_done)
        begin
            sim_reg <= m_sim;
            zn_reg  <= m_zero;
        end
    end

    for (genvar g = 0; g < DIM; g++)
    begin : g_lane
        assign xvec[g*ELEM_BITS +: ELEM_BITS] = x_reg[g];
        ham_lane #(
            .DIM(DIM), .ELEM_BITS(ELEM_BITS), .WEIGHT_BITS(WEIGHT_BITS), .ACC_BITS(ACC_BITS)
        ) u_lane (
            .clk(clk), .rst_n(rst_n), .ctl(ctl), .col(col_reg),
            .row_elem(x_reg[g]), .col_elem(x_reg[col_reg]),
            .acc(rvec[g*ACC_BITS +: ACC_BITS])
        );
    end

    ham_merge #(.DIM(DIM), .ELEM_BITS(ELEM_BITS), .ACC_BITS(ACC_BITS)) u_merge (
        .clk(clk), .rst_n(rst_n), .start(m_start), .rvec(rvec), .xvec(xvec),
        .done(m_done), .sim(m_sim), .zero(m_zero)
    );

    assign out_valid  = ov_reg;
    assign similarity = sim_reg;
    assign zero_norm  = zn_reg;

    `HAM_ASSERT_IMPL(a_no_accept_busy, st_reg != ST_IDLE, !in_acc)
    `HAM_ASSERT_IMPL(a_done_in_check, m_done, st_reg == ST_DIV)
    `HAM_ASSERT_NEXT(a_zero_sim, ov_reg && zn_reg && !out_stall, 1'b1)
    `HAM_ASSERT_IMPL(a_zero_means_zero, ov_reg && zn_reg, sim_reg == '0)
endmodule

[design/ham_lane.sv]
`timescale 1ns / 1ps
// One row of the weight matrix: teach update or recall accumulate, one column per cycle.
module ham_lane #(
    parameter int DIM         = ham_pkg::DIM_DEF,
    parameter int ELEM_BITS   = ham_pkg::ELEM_BITS_DEF,
    parameter int WEIGHT_BITS = ham_pkg::WEIGHT_BITS_DEF,
    parameter int ACC_BITS    = WEIGHT_BITS + ELEM_BITS + 5
)(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ham_pkg::ham_lane_ctl_t              ctl,
    input  logic [$clog2(DIM)-1:0]              col,
    input  logic signed [ELEM_BITS-1:0]         row_elem,
    input  logic signed [ELEM_BITS-1:0]         col_elem,
    output logic signed [ACC_BITS-1:0]          acc
);
    import ham_pkg::*;

    localparam int PROD_BITS = 2 * ELEM_BITS;
    localparam logic signed [WEIGHT_BITS:0] W_MAX =
        $signed({2'b00, {(WEIGHT_BITS-1){1'b1}}});
    localparam logic signed [WEIGHT_BITS:0] W_MIN =
        $signed({2'b11, {(WEIGHT_BITS-1){1'b0}}});

    logic signed [WEIGHT_BITS-1:0] w_reg [DIM];
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [WEIGHT_BITS:0]   upd;
    logic signed [WEIGHT_BITS+ELEM_BITS-1:0] wx;
    logic signed [WEIGHT_BITS-1:0] upd_sat;

    assign prod = row_elem * col_elem;
    assign upd  = WEIGHT_BITS'(w_reg[col]) + (WEIGHT_BITS+1)'(prod);
    assign wx   = w_reg[col] * col_elem;
    assign acc  = acc_reg;

    always_comb
    begin
        if (upd > W_MAX)
            upd_sat = WEIGHT_BITS'(W_MAX);
        else if (upd < W_MIN)
            upd_sat = WEIGHT_BITS'(W_MIN);
        else
            upd_sat = WEIGHT_BITS'(upd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIM; k++)
                w_reg[k] <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (ctl.teach)
                w_reg[col] <= upd_sat;
            if (ctl.mac)
            begin
                if (col == '0)
                    acc_reg <= ACC_BITS'(wx);
                else
                    acc_reg <= acc_reg + ACC_BITS'(wx);
            end
        end
    end
endmodule

[design/ham_merge.sv]
`timescale 1ns / 1ps
// Scaling, dot products, square roots and rounded division of the lane results.
module ham_merge #(
    parameter int DIM       = ham_pkg::DIM_DEF,
    parameter int ELEM_BITS = ham_pkg::ELEM_BITS_DEF,
    parameter int ACC_BITS  = 34
)(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [DIM*ACC_BITS-1:0]              rvec,
    input  logic [DIM*ELEM_BITS-1:0]             xvec,
    output logic                                 done,
    output logic signed [ham_pkg::SIM_BITS-1:0]  sim,
    output logic                                 zero
);
    import ham_pkg::*;

    localparam int IDX_BITS = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int MAGW     = (ACC_BITS > ELEM_BITS) ? ACC_BITS : ELEM_BITS;
    localparam int SHW      = $clog2(MAGW + 1);
    localparam int ROOTW    = 32;
    localparam int NUMW     = SQ_BITS - 29;

    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_MAX  = 6'b000010,
        M_SUMS = 6'b000100,
        M_SQRT = 6'b001000,
        M_MUL  = 6'b010000,
        M_DIV  = 6'b100000
    } m_state_t;

    m_state_t               st_reg, st_next;
    logic [IDX_BITS-1:0]    idx_reg;
    logic [MAGW-1:0]        rmax_reg, xmax_reg;
    logic [SQ_BITS-1:0]     num_reg, rn_reg, xn_reg;
    logic                   nneg_reg;
    logic [SQ_BITS-1:0]     rrem_reg, xrem_reg, rres_reg, xres_reg, bit_reg;
    logic [SQ_BITS-1:0]     den_reg, rem_reg, quo_reg;
    logic [6:0]             cnt_reg;
    logic signed [SIM_BITS-1:0] sim_reg;
    logic                   zero_reg, done_reg;

    logic signed [ACC_BITS-1:0]  r_i;
    logic signed [ELEM_BITS-1:0] x_i;
    logic [MAGW-1:0]        rmag, xmag;
    logic [SHW-1:0]         rsh, xsh;
    logic [SC_BITS-2:0]     rsm, xsm;
    logic [2*SC_BITS-1:0]   rr, xx, rxm;
    logic                   rx_neg;
    logic [SQ_BITS:0]       rtry, xtry, dtry;
    logic [2*ROOTW-1:0]     den_prod;

    assign r_i  = rvec[idx_reg*ACC_BITS +: ACC_BITS];
    assign x_i  = xvec[idx_reg*ELEM_BITS +: ELEM_BITS];
    assign rmag = r_i[ACC_BITS-1] ? -MAGW'(r_i) : MAGW'(r_i);
    assign xmag = x_i[ELEM_BITS-1] ? -MAGW'(x_i) : MAGW'(x_i);

    function automatic logic [SHW-1:0] shift15(input logic [MAGW-1:0] m);
        logic [SHW-1:0] s;
        s = '0;
        for (int b = 15; b < MAGW; b++)
            if (m[b])
                s = SHW'(b - 14);
        return s;
    endfunction

    assign rsh = shift15(rmax_reg);
    assign xsh = shift15(xmax_reg);
    assign rsm = (SC_BITS-1)'(rmag >> rsh);
    assign xsm = (SC_BITS-1)'(xmag >> xsh);
    assign rr  = rsm * rsm;
    assign xx  = xsm * xsm;
    assign rxm = rsm * xsm;
    assign rx_neg = (r_i[ACC_BITS-1] ^ x_i[ELEM_BITS-1]) && rxm != '0;

    assign rtry = {1'b0, rrem_reg} - ({1'b0, rres_reg} + {1'b0, bit_reg});
    assign xtry = {1'b0, xrem_reg} - ({1'b0, xres_reg} + {1'b0, bit_reg});
    assign dtry = {rem_reg, quo_reg[SQ_BITS-1]} - {1'b0, den_reg};
    assign den_prod = rres_reg[ROOTW-1:0] * xres_reg[ROOTW-1:0];

    // signed dot product kept as sign/magnitude in num_reg with sign nneg_reg
    logic [SQ_BITS:0] nsum;
    always_comb
    begin
        if (nneg_reg == rx_neg)
            nsum = {1'b0, num_reg} + (SQ_BITS+1)'(rxm);
        else
            nsum = {1'b0, num_reg} - (SQ_BITS+1)'(rxm);
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            M_IDLE: if (start) st_next = M_MAX;
            M_MAX:  if (idx_reg == IDX_BITS'(DIM-1)) st_next = M_SUMS;
            M_SUMS:
                if (idx_reg == IDX_BITS'(DIM-1))
                    st_next = M_SQRT;
            M_SQRT:
                if (rn_reg == '0 || xn_reg == '0)
                    st_next = M_IDLE;
                else if (bit_reg == '0)
                    st_next = M_MUL;
            M_MUL:  st_next = M_DIV;
            M_DIV:  if (cnt_reg == '0) st_next = M_IDLE;
            default: st_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= M_IDLE;
            idx_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= 1'b0;
            if (st_reg == M_MAX || st_reg == M_SUMS)
                idx_reg <= idx_reg + IDX_BITS'(1);
            if (idx_reg == IDX_BITS'(DIM-1))
                idx_reg <= '0;
            if (st_reg == M_SQRT && (rn_reg == '0 || xn_reg == '0))
                done_reg <= 1'b1;
            if (st_reg == M_DIV && cnt_reg == '0)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            M_IDLE:
            begin
                rmax_reg <= '0;
                xmax_reg <= '0;
                num_reg  <= '0;
                nneg_reg <= 1'b0;
                rn_reg   <= '0;
                xn_reg   <= '0;
            end
            M_MAX:
            begin
                if (rmag > rmax_reg) rmax_reg <= rmag;
                if (xmag > xmax_reg) xmax_reg <= xmag;
            end
            M_SUMS:
            begin
                rn_reg <= rn_reg + SQ_BITS'(rr);
                xn_reg <= xn_reg + SQ_BITS'(xx);
                if (nsum[SQ_BITS])
                begin
                    num_reg  <= SQ_BITS'(-nsum);
                    nneg_reg <= ~nneg_reg;
                end
                else
                begin
                    num_reg <= SQ_BITS'(nsum);
                    if (nsum == '0)
                        nneg_reg <= 1'b0;
                end
                if (idx_reg == IDX_BITS'(DIM-1))
                begin
                    // rn, xn < 2^34, so rn<<14 < 2^48
                    rrem_reg <= (rn_reg + SQ_BITS'(rr)) << 14;
                    xrem_reg <= (xn_reg + SQ_BITS'(xx)) << 14;
                    rres_reg <= '0;
                    xres_reg <= '0;
                    bit_reg  <= SQ_BITS'(1) << 48;
                end
            end
            M_SQRT:
            begin
                if (rn_reg == '0 || xn_reg == '0)
                begin
                    sim_reg  <= '0;
                    zero_reg <= 1'b1;
                end
                if (bit_reg != '0)
                begin
                    if (!rtry[SQ_BITS])
                    begin
                        rrem_reg <= SQ_BITS'(rtry);
                        rres_reg <= (rres_reg >> 1) + bit_reg;
                    end
                    else
                        rres_reg <= rres_reg >> 1;
                    if (!xtry[SQ_BITS])
                    begin
                        xrem_reg <= SQ_BITS'(xtry);
                        xres_reg <= (xres_reg >> 1) + bit_reg;
                    end
                    else
                        xres_reg <= xres_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                end
            end
            M_MUL:
            begin
                den_reg <= SQ_BITS'(den_prod);
                // dividend = num<<29 + den/2, handled in DIV via its first step
                cnt_reg <= 7'(SQ_BITS);
            end
            M_DIV:
            begin
                if (cnt_reg == 7'(SQ_BITS) && quo_reg == '0 && rem_reg == '0)
                begin
                    quo_reg <= (num_reg << 29) + (den_reg >> 1);
                    rem_reg <= '0;
                end
                else if (cnt_reg != '0)
                begin
                    if (!dtry[SQ_BITS])
                        rem_reg <= SQ_BITS'(dtry);
                    else
                        rem_reg <= {rem_reg[SQ_BITS-2:0], quo_reg[SQ_BITS-1]};
                    quo_reg <= {quo_reg[SQ_BITS-2:0], !dtry[SQ_BITS]};
                    cnt_reg <= cnt_reg - 7'd1;
                end
                zero_reg <= 1'b0;
            end
            default: ;
        endcase
        if (st_reg == M_MUL)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
        end
        if (st_reg == M_DIV && cnt_reg == '0)
        begin
            if (nneg_reg)
                sim_reg <= (quo_reg > SQ_BITS'(32768)) ? SIM_BITS'(-32768)
                          : SIM_BITS'(-quo_reg);
            else
                sim_reg <= (quo_reg > SQ_BITS'(32767)) ? SIM_BITS'(32767)
                          : SIM_BITS'(quo_reg);
        end
    end

    assign done = done_reg;
    assign sim  = sim_reg;
    assign zero = zero_reg;
endmodule

[bench/hebbian_checker.sv]
`timescale 1ns / 1ps
module hebbian_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               req_type,
    input  logic signed [7:0]  elem_0,
    input  logic signed [7:0]  elem_1,
    input  logic signed [7:0]  elem_2,
    input  logic signed [7:0]  elem_3,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] similarity,
    input  logic               zero_norm,
    input  logic               end_of_run,
    output int                 errors,
    output int                 pending
);
    import ham_pkg::*;

    typedef longint vec_t [4];
    typedef struct {
        logic signed [15:0] sim;
        logic               zn;
    } cosine_word_t;

    longint       weights [16];
    cosine_word_t cosine_q [$];
    bit           swept;

    assign pending = cosine_q.size();

    initial errors = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint sat_weight(input longint v);
        longint hi;
        hi = (longint'(1) <<< 23) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint unsigned mag(input longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitpos;
        res = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > n)
            bitpos >>= 2;
        while (bitpos != 0)
        begin
            if (n >= res + bitpos)
            begin
                n -= res + bitpos;
                res = (res >> 1) + bitpos;
            end
            else
                res >>= 1;
            bitpos >>= 2;
        end
        return res;
    endfunction

    // bring every magnitude below 2^15, truncating magnitudes
    function automatic vec_t fit15(input vec_t v);
        longint unsigned mx;
        int              sh;
        vec_t            o;
        mx = 0;
        sh = 0;
        for (int k = 0; k < 4; k++)
            if (mag(v[k]) > mx)
                mx = mag(v[k]);
        while (mx >= 32768)
        begin
            mx >>= 1;
            sh++;
        end
        for (int k = 0; k < 4; k++)
            o[k] = (v[k] < 0) ? -longint'(mag(v[k]) >> sh) : longint'(mag(v[k]) >> sh);
        return o;
    endfunction

    function automatic cosine_word_t recall_cosine(input vec_t x);
        vec_t            r, rs, xs;
        longint          num;
        longint unsigned rn, xn, den, q;
        cosine_word_t    w;
        num = 0;
        rn = 0;
        xn = 0;
        for (int i = 0; i < 4; i++)
        begin
            r[i] = 0;
            for (int j = 0; j < 4; j++)
                r[i] += weights[i*4+j] * x[j];
        end
        rs = fit15(r);
        xs = fit15(x);
        for (int i = 0; i < 4; i++)
        begin
            num += rs[i] * xs[i];
            rn += rs[i] * rs[i];
            xn += xs[i] * xs[i];
        end
        if (rn == 0 || xn == 0)
        begin
            w.sim = '0;
            w.zn = 1'b1;
            return w;
        end
        den = int_root(rn << 14) * int_root(xn << 14);
        q = ((mag(num) << 29) + den / 2) / den;
        if (num < 0)
            w.sim = (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
        else
            w.sim = (q > 32767) ? 16'sd32767 : 16'(q);
        w.zn = 1'b0;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vec_t         x;
        cosine_word_t got;
        cosine_word_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
                weights[k] = 0;
            cosine_q.delete();
            swept = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                x[0] = elem_0;
                x[1] = elem_1;
                x[2] = elem_2;
                x[3] = elem_3;
                if (req_type == REQ_TEACH)
                begin
                    for (int i = 0; i < 4; i++)
                        for (int j = 0; j < 4; j++)
                            weights[i*4+j] = sat_weight(weights[i*4+j] + x[i] * x[j]);
                end
                else
                    cosine_q.push_back(recall_cosine(x));
            end
            if (out_valid && !out_stall)
            begin
                got.sim = similarity;
                got.zn = zero_norm;
                if (cosine_q.size() == 0)
                    report($sformatf("unexpected word sim=%0d zero_norm=%0b",
                                     got.sim, got.zn));
                else
                begin
                    want = cosine_q.pop_front();
                    if (got.sim !== want.sim)
                        report($sformatf("similarity got %0d want %0d", got.sim, want.sim));
                    if (got.zn !== want.zn)
                        report($sformatf("zero_norm got %0b want %0b", got.zn, want.zn));
                end
            end
            if (end_of_run && !swept)
            begin
                swept = 1'b1;
                while (cosine_q.size() > 0)
                begin
                    want = cosine_q.pop_front();
                    report($sformatf("missing word sim=%0d zero_norm=%0b",
                                     want.sim, want.zn));
                end
            end
        end
    end
endmodule

[bench/tb_hebbian_assoc_memory_top.sv]
`timescale 1ns / 1ps
module tb_hebbian_assoc_memory_top;
    import ham_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic signed [7:0]  elem_0, elem_1, elem_2, elem_3;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] similarity;
    logic               zero_norm;
    logic               end_of_run;
    int                 errors;
    int                 pending;
    bit                 calm;
    int                 teach_count;
    int                 check_count;

    hebbian_assoc_memory_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
        .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
        .out_valid(out_valid), .out_stall(out_stall),
        .similarity(similarity), .zero_norm(zero_norm)
    );

    hebbian_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
        .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
        .out_valid(out_valid), .out_stall(out_stall),
        .similarity(similarity), .zero_norm(zero_norm),
        .end_of_run(end_of_run), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout waiting on the block");
        $display("hebbian_assoc_memory_top regression: fail");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // caller sits at a rising edge; returns at the edge the word is taken
    task automatic send(input logic req, input logic signed [7:0] a, b, c, d);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        elem_0 <= a;
        elem_1 <= b;
        elem_2 <= c;
        elem_3 <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (req == REQ_TEACH)
            teach_count++;
        else
            check_count++;
    endtask

    function automatic logic signed [7:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 8'($urandom_range(0, 6)) - 8'sd3;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random();
        logic req;
        req = $urandom_range(0, 1);
        if ($urandom_range(0, 15) == 0)
            send(req, 0, 0, 0, 0);
        else
            send(req, rand_elem(), rand_elem(), rand_elem(), rand_elem());
    endtask

    // output side: random stalls after each word is taken and at other times, none when calm
    initial
    begin
        int n;
        n = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                n = draw_gap();
                if (n > 0)
                    out_stall <= 1'b1;
            end
            else if (n > 0)
            begin
                n--;
                if (n == 0)
                    out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        logic signed [7:0] p [4];
        int                wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_TEACH;
        elem_0 = 0;
        elem_1 = 0;
        elem_2 = 0;
        elem_3 = 0;
        end_of_run = 1'b0;
        calm = 1'b0;
        teach_count = 0;
        check_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty weights give zero norm, as does a zero vector
        send(REQ_CHECK, 8'sd127, -8'sd128, 8'sd1, -8'sd1);
        send(REQ_CHECK, 0, 0, 0, 0);
        send(REQ_TEACH, 8'sd5, 0, 0, 0);
        // single pattern stored: recall is parallel, cosine of one; else zero norm
        send(REQ_CHECK, 8'sd5, 0, 0, 0);
        send(REQ_CHECK, -8'sd128, 0, 0, 0);
        send(REQ_CHECK, 0, 8'sd127, 0, 0);
        send(REQ_CHECK, 0, 0, 0, 0);
        send(REQ_TEACH, -8'sd128, -8'sd128, -8'sd128, -8'sd128);
        send(REQ_TEACH, 8'sd127, -8'sd128, 8'sd127, -8'sd128);
        send(REQ_CHECK, 8'sd127, 8'sd127, 8'sd127, 8'sd127);
        send(REQ_CHECK, -8'sd128, 8'sd127, -8'sd128, 8'sd127);
        send(REQ_CHECK, 8'sd1, -8'sd1, 8'sd1, 8'sd1);
        send(REQ_TEACH, 8'sd1, 8'sd2, -8'sd3, 8'sd4);
        send(REQ_CHECK, -8'sd1, -8'sd2, 8'sd3, -8'sd4);
        send(REQ_CHECK, 8'sd0, 8'sd0, 8'sd0, -8'sd128);
        send(REQ_TEACH, 0, 0, 0, 0);
        send(REQ_CHECK, 8'sd85, -8'sd86, 8'sd42, -8'sd43);

        for (int i = 0; i < 300; i++)
        begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_random();
        end
        calm = 1'b0;

        // drive weights into saturation with a random sign pattern, checking on the way
        for (int k = 0; k < 4; k++)
            p[k] = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
        for (int i = 0; i < 560; i++)
        begin
            if (i % 20 == 19)
                send_random();
            else
                send(REQ_TEACH, p[0], p[1], p[2], p[3]);
        end
        send(REQ_CHECK, p[0], p[1], p[2], p[3]);
        for (int i = 0; i < 10; i++)
            send(REQ_CHECK, rand_elem(), rand_elem(), rand_elem(), rand_elem());
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending > 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge clk);

        $display("covered %0d teach and %0d check words, incl. zero norm and saturation",
                 teach_count, check_count);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("hebbian_assoc_memory_top regression: pass");
        else
            $display("hebbian_assoc_memory_top regression: fail");
        $finish;
    end
endmodule

[sim.f]
+incdir+design
design/ham_pkg.sv
design/ham_lane.sv
design/ham_merge.sv
design/hebbian_assoc_memory_top.sv
bench/hebbian_checker.sv
bench/tb_hebbian_assoc_memory_top.sv
